[hw/rtl/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared widths, codes, stream layouts and types of the sprite projection core.
// ----------------------------------------------------------------------------
package ssp_pkg;

  // number formats
  localparam int FRAC_BITS  = 16;
  localparam int MAX_SCREEN = 4096;
  localparam int POS_W      = 26;
  localparam int VEC_W      = 19;
  localparam int DIM_W      = 13;

  // camera-space transform datapath
  localparam int REL_W  = POS_W + 1;
  localparam int PROD_W = VEC_W + REL_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int MAG_W  = NUM_W - 1;
  localparam int DVD_W  = MAG_W + FRAC_BITS;
  localparam int DETP_W = 2 * VEC_W;
  localparam int DET_W  = DETP_W + 1;
  localparam int DETM_W = DET_W - 1;
  localparam int T_W    = 32;
  localparam int QT_W   = T_W + 1;
  localparam int XCMP_W = DETM_W + QT_W;

  // column and size datapath
  localparam int SUM_W  = T_W + 1;
  localparam int HW_W   = DIM_W - 1;
  localparam int CNUM_W = HW_W + 1 + SUM_W;
  localparam int CMAG_W = CNUM_W - 1;
  localparam int CQ_W   = 17;
  localparam int CCMP_W = T_W + CQ_W;

  // result field widths
  localparam int COL_W   = 17;
  localparam int SIZE_W  = 16;
  localparam int TOP_W   = 11;
  localparam int BOT_W   = 12;
  localparam int LEFT_W  = 16;
  localparam int RIGHT_W = 17;
  localparam int STAT_W  = 2;

  // stream layouts
  localparam int IN_X_LSB    = 0;
  localparam int IN_Y_LSB    = IN_X_LSB + POS_W;
  localparam int IN_USED_W   = IN_Y_LSB + POS_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  localparam int OUT_DEPTH_LSB = 0;
  localparam int OUT_COL_LSB   = OUT_DEPTH_LSB + T_W;
  localparam int OUT_SIZE_LSB  = OUT_COL_LSB + COL_W;
  localparam int OUT_TOP_LSB   = OUT_SIZE_LSB + SIZE_W;
  localparam int OUT_BOT_LSB   = OUT_TOP_LSB + TOP_W;
  localparam int OUT_LEFT_LSB  = OUT_BOT_LSB + BOT_W;
  localparam int OUT_RIGHT_LSB = OUT_LEFT_LSB + LEFT_W;
  localparam int OUT_STAT_LSB  = OUT_RIGHT_LSB + RIGHT_W;
  localparam int OUT_USED_W    = OUT_STAT_LSB + STAT_W;
  localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = POS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_X,
    REG_POS_Y,
    REG_DIR_X,
    REG_DIR_Y,
    REG_PLANE_X,
    REG_PLANE_Y,
    REG_WIDTH,
    REG_HEIGHT
  } ssp_reg_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK,
    ST_ZERO_DEPTH,
    ST_SINGULAR
  } ssp_status_t;

  // camera setup seen by the transform unit
  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [VEC_W-1:0] dir_x;
    logic [VEC_W-1:0] dir_y;
    logic [VEC_W-1:0] plane_x;
    logic [VEC_W-1:0] plane_y;
  } ssp_cam_t;

  // transform unit result stage
  typedef struct packed {
    logic           valid;
    logic           singular;
    logic [T_W-1:0] tx;
    logic [T_W-1:0] ty;
  } ssp_xform_t;

endpackage

[hw/rtl/ssp_transform.sv]
// ----------------------------------------------------------------------------
// ssp_transform
// Camera-space transform: offset, cross products and two pipelined
// restoring dividers by the camera determinant, one quotient bit a stage.
// ----------------------------------------------------------------------------
module ssp_transform (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [ssp_pkg::POS_W-1:0] sprite_x,
  input  logic [ssp_pkg::POS_W-1:0] sprite_y,
  input  ssp_pkg::ssp_cam_t        cam,
  output ssp_pkg::ssp_xform_t      xf
);
  import ssp_pkg::*;

  localparam int NSTG = QT_W;
  localparam logic [QT_W-1:0] Q_LIM = QT_W'(1) << (T_W - 1);
  localparam logic [T_W-1:0]  POS_MAX = {1'b0, {(T_W-1){1'b1}}};

  // determinant follows the camera registers
  logic signed [DETP_W-1:0] det_p1, det_p2;
  logic signed [DET_W-1:0]  det;
  logic [DETM_W-1:0]        det_mag;
  logic                     det_neg, det_zero;

  // front stages
  logic                     v1, v2, v3, v4;
  logic signed [REL_W-1:0]  rx, ry;
  logic signed [PROD_W-1:0] p_dyrx, p_dxry, p_pxry, p_pyrx;
  logic signed [NUM_W-1:0]  num_x, num_y;
  logic [DVD_W-1:0]         a_x, a_y;
  logic                     ng_x, ng_y;

  // divider stages
  logic                     vs    [0:NSTG];
  logic [DVD_W-1:0]         rem_x [0:NSTG];
  logic [DVD_W-1:0]         rem_y [0:NSTG];
  logic [QT_W-1:0]          quo_x [0:NSTG];
  logic [QT_W-1:0]          quo_y [0:NSTG];
  logic                     ovf_x [0:NSTG];
  logic                     ovf_y [0:NSTG];
  logic                     neg_x [0:NSTG];
  logic                     neg_y [0:NSTG];

  // result stage
  logic                     f_v;
  logic [T_W-1:0]           f_tx, f_ty;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [NUM_W-1:0] v);
    return v[NUM_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  // clamp the magnitude to 2^31 and apply the sign
  function automatic logic [T_W-1:0] sat_q(input logic [QT_W-1:0] q, input logic ovf,
                                           input logic neg);
    logic [QT_W-1:0] m;
    m = (ovf || q > Q_LIM) ? Q_LIM : q;
    if (neg) return T_W'(-m);
    if (m == Q_LIM) return POS_MAX;
    return T_W'(m);
  endfunction

  // determinant and its magnitude
  always_ff @(posedge clk) begin
    det_p1   <= $signed(cam.plane_x) * $signed(cam.dir_y);
    det_p2   <= $signed(cam.dir_x) * $signed(cam.plane_y);
    det      <= DET_W'(det_p1) - DET_W'(det_p2);
    det_mag  <= det[DET_W-1] ? DETM_W'(-det) : DETM_W'(det);
    det_neg  <= det[DET_W-1];
    det_zero <= (det == '0);
  end

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      vs[0] <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      vs[0] <= v4;
    end
  end

  // offset, products, numerators, magnitudes, overflow check
  always_ff @(posedge clk) begin
    if (en) begin
      rx       <= $signed({1'b0, sprite_x}) - $signed({1'b0, cam.pos_x});
      ry       <= $signed({1'b0, sprite_y}) - $signed({1'b0, cam.pos_y});
      p_dyrx   <= $signed(cam.dir_y) * rx;
      p_dxry   <= $signed(cam.dir_x) * ry;
      p_pxry   <= $signed(cam.plane_x) * ry;
      p_pyrx   <= $signed(cam.plane_y) * rx;
      num_x    <= NUM_W'(p_dyrx) - NUM_W'(p_dxry);
      num_y    <= NUM_W'(p_pxry) - NUM_W'(p_pyrx);
      a_x      <= {mag_of(num_x), {FRAC_BITS{1'b0}}};
      a_y      <= {mag_of(num_y), {FRAC_BITS{1'b0}}};
      ng_x     <= num_x[NUM_W-1] ^ det_neg;
      ng_y     <= num_y[NUM_W-1] ^ det_neg;
      rem_x[0] <= a_x;
      rem_y[0] <= a_y;
      quo_x[0] <= '0;
      quo_y[0] <= '0;
      ovf_x[0] <= {{(XCMP_W-DVD_W){1'b0}}, a_x} >= {det_mag, {QT_W{1'b0}}};
      ovf_y[0] <= {{(XCMP_W-DVD_W){1'b0}}, a_y} >= {det_mag, {QT_W{1'b0}}};
      neg_x[0] <= ng_x;
      neg_y[0] <= ng_y;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 1; s <= NSTG; s++) begin : g_div
    localparam int K = QT_W - s;
    logic [XCMP_W-1:0] dsh;
    logic              fit_x, fit_y;

    assign dsh   = XCMP_W'(det_mag) << K;
    assign fit_x = {{(XCMP_W-DVD_W){1'b0}}, rem_x[s-1]} >= dsh;
    assign fit_y = {{(XCMP_W-DVD_W){1'b0}}, rem_y[s-1]} >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[s] <= 1'b0;
      end else if (en) begin
        vs[s] <= vs[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_x[s] <= fit_x ? rem_x[s-1] - DVD_W'(dsh) : rem_x[s-1];
        rem_y[s] <= fit_y ? rem_y[s-1] - DVD_W'(dsh) : rem_y[s-1];
        quo_x[s] <= quo_x[s-1] | (fit_x ? (QT_W'(1) << K) : QT_W'(0));
        quo_y[s] <= quo_y[s-1] | (fit_y ? (QT_W'(1) << K) : QT_W'(0));
        ovf_x[s] <= ovf_x[s-1];
        ovf_y[s] <= ovf_y[s-1];
        neg_x[s] <= neg_x[s-1];
        neg_y[s] <= neg_y[s-1];
      end
    end
  end

  // saturate and sign, singular camera gives zero
  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en) begin
      f_v <= vs[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_tx <= det_zero ? '0 : sat_q(quo_x[NSTG], ovf_x[NSTG], neg_x[NSTG]);
      f_ty <= det_zero ? '0 : sat_q(quo_y[NSTG], ovf_y[NSTG], neg_y[NSTG]);
    end
  end

  assign xf.valid    = f_v;
  assign xf.singular = det_zero;
  assign xf.tx       = f_tx;
  assign xf.ty       = f_ty;

endmodule

[hw/rtl/sprite_screen_projection_core.sv]
// ----------------------------------------------------------------------------
// sprite_screen_projection_core
// Projects one sprite map position to depth, screen column, size and a
// clamped drawing rectangle for a ray-casting renderer.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  ----------+-----------+-----------------------------------------------------
//  s_*       | in        | sprite_x, sprite_y
//  m_*       | out       | depth, screen_column, sprite_size, top_row,
//            |           | bottom_row, left_column, right_column, status
//  cfg_*     | in        | camera position, direction, plane, screen size
//
//  One sprite is accepted per cycle while the skid entry is empty; the path
//  from the input transfer to the output register has 63 register stages, set by the two chains
//  of one-bit restoring divider stages (33 for the transform, 17 for column
//  and size).
//  rst is synchronous and clears all valid bits and restores the camera setup.
//  A stall on m_* fills a one-entry skid register; s_tready then drops and
//  the pipeline holds until the skid entry drains.
// ----------------------------------------------------------------------------
module sprite_screen_projection_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // sprite_x, sprite_y, zero pad
  input  logic [ssp_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // depth, screen_column, sprite_size, top_row, bottom_row, left_column,
  // right_column, status, zero pad
  output logic [ssp_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                             cfg_wen,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ssp_pkg::*;

  localparam int RECT_W = 18;
  localparam logic [CQ_W-1:0] COL_NEG_LIM = CQ_W'(65536);
  localparam logic [CQ_W-1:0] COL_POS_LIM = CQ_W'(65535);
  localparam logic [CQ_W-1:0] SIZE_LIM    = CQ_W'(65535);
  localparam logic signed [RECT_W-1:0] TOP_LIM = RECT_W'(MAX_SCREEN / 2 - 1);
  localparam logic signed [RECT_W-1:0] SCR_LIM = RECT_W'(MAX_SCREEN - 1);

  // configuration registers
  logic [POS_W-1:0] cam_pos_x, cam_pos_y;
  logic [VEC_W-1:0] cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;
  logic [DIM_W-1:0] screen_width, screen_height;
  logic [HW_W-1:0]  half_w;
  logic [HW_W-1:0]  half_h;

  ssp_cam_t   cam;
  ssp_xform_t xf;
  logic       en;

  // column and size stages
  logic                     u1_v, u2_v, u3_v;
  logic signed [SUM_W-1:0]  u1_sum;
  logic [T_W-1:0]           u1_ty, u2_ty, u3_ty;
  logic [T_W-1:0]           u1_tymag, u2_tymag, u3_tymag;
  logic                     u1_tyneg, u2_tyneg;
  logic                     u1_tyzero, u2_tyzero, u3_tyzero;
  logic                     u1_sing, u2_sing, u3_sing;
  logic signed [CNUM_W-1:0] u2_num;
  logic [CMAG_W-1:0]        u3_cmag;
  logic                     u3_cneg;
  logic [CMAG_W-1:0]        sdvd;

  logic                     dv     [0:CQ_W];
  logic [CMAG_W-1:0]        crem   [0:CQ_W];
  logic [CMAG_W-1:0]        srem   [0:CQ_W];
  logic [CQ_W-1:0]          cquo   [0:CQ_W];
  logic [CQ_W-1:0]          squo   [0:CQ_W];
  logic                     covf   [0:CQ_W];
  logic                     sovf   [0:CQ_W];
  logic                     cneg   [0:CQ_W];
  logic [T_W-1:0]           dty    [0:CQ_W];
  logic [T_W-1:0]           dtymag [0:CQ_W];
  logic                     dzero  [0:CQ_W];
  logic                     dsing  [0:CQ_W];

  // final and rectangle stages
  logic                     u22_v, u23_v;
  logic [T_W-1:0]           u22_ty, u23_ty;
  logic signed [COL_W-1:0]  u22_col, u23_col;
  logic [SIZE_W-1:0]        u22_size, u23_size;
  logic [STAT_W-1:0]        u22_stat, u23_stat;
  logic [TOP_W-1:0]         u23_top;
  logic [BOT_W-1:0]         u23_bot;
  logic [LEFT_W-1:0]        u23_left;
  logic [RIGHT_W-1:0]       u23_right;

  logic [CQ_W-1:0]          f_cm;
  logic signed [COL_W-1:0]  f_col;
  logic [SIZE_W-1:0]        f_size;
  logic [STAT_W-1:0]        f_stat;

  logic [SIZE_W-2:0]        hs;
  logic signed [RECT_W-1:0] top_s, bot_s, left_s, right_s, hsig, wsig;
  logic [TOP_W-1:0]         r_top;
  logic [BOT_W-1:0]         r_bot;
  logic [LEFT_W-1:0]        r_left;
  logic [RIGHT_W-1:0]       r_right;

  // output register and skid entry
  logic                     out_v, skid_v;
  logic [OUT_TDATA_W-1:0]   out_d, skid_d, pack;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cam_pos_x     <= '0;
      cam_pos_y     <= '0;
      cam_dir_x     <= VEC_W'(65536);
      cam_dir_y     <= '0;
      cam_plane_x   <= '0;
      cam_plane_y   <= VEC_W'(43253);
      screen_width  <= DIM_W'(640);
      screen_height <= DIM_W'(480);
    end else if (cfg_wen) begin
      case (ssp_reg_t'(cfg_addr))
        REG_POS_X:   cam_pos_x     <= cfg_wdata;
        REG_POS_Y:   cam_pos_y     <= cfg_wdata;
        REG_DIR_X:   cam_dir_x     <= cfg_wdata[VEC_W-1:0];
        REG_DIR_Y:   cam_dir_y     <= cfg_wdata[VEC_W-1:0];
        REG_PLANE_X: cam_plane_x   <= cfg_wdata[VEC_W-1:0];
        REG_PLANE_Y: cam_plane_y   <= cfg_wdata[VEC_W-1:0];
        REG_WIDTH:   screen_width  <= cfg_wdata[DIM_W-1:0];
        REG_HEIGHT:  screen_height <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign half_w = screen_width[DIM_W-1:1];
  assign half_h = screen_height[DIM_W-1:1];
  assign sdvd   = CMAG_W'({screen_height, {FRAC_BITS{1'b0}}});

  assign cam.pos_x   = cam_pos_x;
  assign cam.pos_y   = cam_pos_y;
  assign cam.dir_x   = cam_dir_x;
  assign cam.dir_y   = cam_dir_y;
  assign cam.plane_x = cam_plane_x;
  assign cam.plane_y = cam_plane_y;

  // pipeline advances unless the skid entry is occupied
  assign en       = ~skid_v;
  assign s_tready = en;

  ssp_transform u_xform (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .sprite_x (s_tdata[IN_X_LSB +: POS_W]),
    .sprite_y (s_tdata[IN_Y_LSB +: POS_W]),
    .cam      (cam),
    .xf       (xf)
  );

  // valid bits of the column and size front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      u1_v  <= 1'b0;
      u2_v  <= 1'b0;
      u3_v  <= 1'b0;
      dv[0] <= 1'b0;
    end else if (en) begin
      u1_v  <= xf.valid;
      u2_v  <= u1_v;
      u3_v  <= u2_v;
      dv[0] <= u3_v;
    end
  end

  // tx + ty, column numerator, magnitudes, overflow checks
  always_ff @(posedge clk) begin
    if (en) begin
      u1_sum    <= SUM_W'($signed(xf.tx)) + SUM_W'($signed(xf.ty));
      u1_ty     <= xf.ty;
      u1_tymag  <= xf.ty[T_W-1] ? T_W'(-SUM_W'($signed(xf.ty))) : xf.ty;
      u1_tyneg  <= xf.ty[T_W-1];
      u1_tyzero <= (xf.ty == '0);
      u1_sing   <= xf.singular;

      u2_num    <= $signed({1'b0, half_w}) * u1_sum;
      u2_ty     <= u1_ty;
      u2_tymag  <= u1_tymag;
      u2_tyneg  <= u1_tyneg;
      u2_tyzero <= u1_tyzero;
      u2_sing   <= u1_sing;

      u3_cmag   <= u2_num[CNUM_W-1] ? CMAG_W'(-u2_num) : CMAG_W'(u2_num);
      u3_cneg   <= u2_num[CNUM_W-1] ^ u2_tyneg;
      u3_ty     <= u2_ty;
      u3_tymag  <= u2_tymag;
      u3_tyzero <= u2_tyzero;
      u3_sing   <= u2_sing;

      crem[0]   <= u3_cmag;
      srem[0]   <= sdvd;
      cquo[0]   <= '0;
      squo[0]   <= '0;
      covf[0]   <= {{(CCMP_W-CMAG_W){1'b0}}, u3_cmag} >= {u3_tymag, {CQ_W{1'b0}}};
      sovf[0]   <= {{(CCMP_W-CMAG_W){1'b0}}, sdvd} >= {u3_tymag, {CQ_W{1'b0}}};
      cneg[0]   <= u3_cneg;
      dty[0]    <= u3_ty;
      dtymag[0] <= u3_tymag;
      dzero[0]  <= u3_tyzero;
      dsing[0]  <= u3_sing;
    end
  end

  // column and size quotients by |ty|, one bit per stage
  for (genvar s = 1; s <= CQ_W; s++) begin : g_div
    localparam int K = CQ_W - s;
    logic [CCMP_W-1:0] dsh;
    logic              fit_c, fit_s;

    assign dsh   = CCMP_W'(dtymag[s-1]) << K;
    assign fit_c = {{(CCMP_W-CMAG_W){1'b0}}, crem[s-1]} >= dsh;
    assign fit_s = {{(CCMP_W-CMAG_W){1'b0}}, srem[s-1]} >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s] <= 1'b0;
      end else if (en) begin
        dv[s] <= dv[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        crem[s]   <= fit_c ? crem[s-1] - CMAG_W'(dsh) : crem[s-1];
        srem[s]   <= fit_s ? srem[s-1] - CMAG_W'(dsh) : srem[s-1];
        cquo[s]   <= cquo[s-1] | (fit_c ? (CQ_W'(1) << K) : CQ_W'(0));
        squo[s]   <= squo[s-1] | (fit_s ? (CQ_W'(1) << K) : CQ_W'(0));
        covf[s]   <= covf[s-1];
        sovf[s]   <= sovf[s-1];
        cneg[s]   <= cneg[s-1];
        dty[s]    <= dty[s-1];
        dtymag[s] <= dtymag[s-1];
        dzero[s]  <= dzero[s-1];
        dsing[s]  <= dsing[s-1];
      end
    end
  end

  // saturate column and size, zero depth override, status
  always_comb begin
    f_cm = (covf[CQ_W] || cquo[CQ_W] > COL_NEG_LIM) ? COL_NEG_LIM : cquo[CQ_W];
    if (dzero[CQ_W]) begin
      f_col  = COL_W'(half_w);
      f_size = '1;
    end else begin
      if (cneg[CQ_W]) begin
        f_col = COL_W'(-f_cm);
      end else begin
        f_col = (f_cm > COL_POS_LIM) ? COL_W'(COL_POS_LIM) : COL_W'(f_cm);
      end
      f_size = (sovf[CQ_W] || squo[CQ_W] > SIZE_LIM) ? '1 : SIZE_W'(squo[CQ_W]);
    end
    if (dsing[CQ_W]) begin
      f_stat = ST_SINGULAR;
    end else if (dzero[CQ_W]) begin
      f_stat = ST_ZERO_DEPTH;
    end else begin
      f_stat = ST_OK;
    end
  end

  // drawing rectangle from column and half size
  always_comb begin
    hs      = u22_size[SIZE_W-1:1];
    hsig    = $signed(RECT_W'(screen_height));
    wsig    = $signed(RECT_W'(screen_width));

    top_s   = $signed(RECT_W'(half_h) - RECT_W'(hs));
    if (top_s < 0) begin
      r_top = '0;
    end else if (top_s > TOP_LIM) begin
      r_top = TOP_W'(TOP_LIM);
    end else begin
      r_top = top_s[TOP_W-1:0];
    end

    bot_s   = $signed(RECT_W'(hs) + RECT_W'(half_h));
    if (bot_s >= hsig) bot_s = hsig - RECT_W'(1);
    if (bot_s < 0) begin
      r_bot = '0;
    end else if (bot_s > SCR_LIM) begin
      r_bot = BOT_W'(SCR_LIM);
    end else begin
      r_bot = bot_s[BOT_W-1:0];
    end

    left_s  = $signed(RECT_W'(u22_col) - RECT_W'(hs));
    r_left  = (left_s < 0) ? '0 : left_s[LEFT_W-1:0];

    right_s = $signed(RECT_W'(u22_col) + RECT_W'(hs));
    if (right_s >= wsig) right_s = wsig - RECT_W'(1);
    if (right_s > SCR_LIM) right_s = SCR_LIM;
    r_right = right_s[RIGHT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u22_v <= 1'b0;
      u23_v <= 1'b0;
    end else if (en) begin
      u22_v <= dv[CQ_W];
      u23_v <= u22_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u22_ty    <= dty[CQ_W];
      u22_col   <= f_col;
      u22_size  <= f_size;
      u22_stat  <= f_stat;
      u23_ty    <= u22_ty;
      u23_col   <= u22_col;
      u23_size  <= u22_size;
      u23_stat  <= u22_stat;
      u23_top   <= r_top;
      u23_bot   <= r_bot;
      u23_left  <= r_left;
      u23_right <= r_right;
    end
  end

  // result word
  assign pack = {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, u23_stat, u23_right, u23_left,
                 u23_bot, u23_top, u23_size, u23_col, u23_ty};

  // output register with a one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (en) begin
      if (!out_v || m_tready) begin
        out_v <= u23_v;
      end else if (u23_v) begin
        skid_v <= 1'b1;
      end
    end else if (m_tready) begin
      skid_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!out_v || m_tready) begin
        out_d <= pack;
      end else begin
        skid_d <= pack;
      end
    end else if (m_tready) begin
      out_d <= skid_d;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = out_d;

endmodule

[hw/rtl/ssp_checker.sv]
// ----------------------------------------------------------------------------
// ssp_checker
// Port-level checks of the sprite projection core, bound to its top level.
// ----------------------------------------------------------------------------
module ssp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ssp_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import ssp_pkg::*;

  logic [T_W-1:0]    depth;
  logic [SIZE_W-1:0] size;
  logic [TOP_W-1:0]  top;
  logic [BOT_W-1:0]  bot;
  logic [STAT_W-1:0] stat;

  assign depth = m_tdata[OUT_DEPTH_LSB +: T_W];
  assign size  = m_tdata[OUT_SIZE_LSB +: SIZE_W];
  assign top   = m_tdata[OUT_TOP_LSB +: TOP_W];
  assign bot   = m_tdata[OUT_BOT_LSB +: BOT_W];
  assign stat  = m_tdata[OUT_STAT_LSB +: STAT_W];

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // zero depth or singular camera gives depth 0 and full size
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (stat == ST_ZERO_DEPTH || stat == ST_SINGULAR)
      |-> depth == '0 && size == '1)
    else $error("zero depth result fields wrong");

  // drawn rows never invert
  a_rows: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> BOT_W'(top) <= bot)
    else $error("top row below bottom row");

endmodule

bind sprite_screen_projection_core ssp_checker u_ssp_checker (.*);
